// ===== design/pbl_pkg.sv =====
package pbl_pkg;

    localparam int PBL_TABLE_ENTRIES = 64;

    localparam int PBL_COUNT_W = 7;
    localparam logic [PBL_COUNT_W-1:0] PBL_COUNT_MAX = '1;

    localparam logic [2:0] OP_CHECK         = 3'd0;
    localparam logic [2:0] OP_ADD           = 3'd1;
    localparam logic [2:0] OP_REMOVE        = 3'd2;
    localparam logic [2:0] OP_PURGE_EXPIRED = 3'd3;
    localparam logic [2:0] OP_PURGE_ALL     = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [30:0] duration_secs;
        logic [31:0] now_secs;
    } t_req;

    typedef struct packed {
        logic [30:0]            remaining_secs;
        logic                   status;
        logic [PBL_COUNT_W-1:0] purged_count;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [15:0] udp_port;
        logic [31:0] expiry;
    } t_entry;

endpackage

// ===== design/pbl_ram.sv =====
module pbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/peer_blocklist_with_expiry.sv =====
// Channel   Direction  Handshake                 Word
// request   in         start high, busy low      i_req  (op, peer, duration, now)
// result    out        o_done, one cycle         o_rsp  (remaining, status, count)
//
// Every request sweeps the whole table through the entry memory, one read per
// cycle, then writes back in S_FINISH and registers the result, which is shown on
// o_done once the block is back in S_IDLE. busy falls in the o_done cycle, so the
// next word can be taken then. After reset a clearing pass writes every entry
// invalid with busy high. The receiver cannot stall; each result is shown once.
module peer_blocklist_with_expiry #(
    parameter int TABLE_ENTRIES = pbl_pkg::PBL_TABLE_ENTRIES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  pbl_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output pbl_pkg::t_rsp o_rsp
);
    import pbl_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = $bits(t_entry);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_FINISH} t_state;

    t_state           r_state;
    t_req             r_req;
    logic [CW-1:0]    r_rd_cnt;
    logic             r_pv;
    logic [IW-1:0]    r_pidx;
    logic             r_found;
    logic [IW-1:0]    r_hit_idx;
    logic [30:0]      r_rem;
    logic             r_free_found;
    logic [IW-1:0]    r_free_idx;
    logic [PBL_COUNT_W-1:0] r_count;
    logic             r_done;
    t_rsp             r_rsp;

    logic             rd_en;
    logic [EW-1:0]    rd_word;
    t_entry           rd_entry;
    logic [31:0]      diff;
    logic             expired;
    logic             hit;
    logic             is_lookup;
    logic             purge_sel;
    logic [31:0]      new_exp;
    logic             add_full;

    logic             we;
    logic [IW-1:0]    waddr;
    t_entry           wr_entry;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    assign rd_en    = (r_state == S_SCAN) && (r_rd_cnt != CW'(TABLE_ENTRIES));
    assign rd_entry = t_entry'(rd_word);

    // Wrap-safe expiry: the entry is expired when expiry - now is zero or negative.
    assign diff    = rd_entry.expiry - r_req.now_secs;
    assign expired = (diff == 32'd0) || diff[31];
    assign hit     = rd_entry.valid && (rd_entry.addr == r_req.peer_ip)
                     && (rd_entry.udp_port == r_req.peer_port);

    assign is_lookup = (r_req.op == OP_CHECK) || (r_req.op == OP_ADD)
                       || (r_req.op == OP_REMOVE);
    assign purge_sel = rd_entry.valid && ((r_req.op == OP_PURGE_ALL)
                       || ((r_req.op == OP_PURGE_EXPIRED) && expired));

    assign new_exp  = r_req.now_secs + {1'b0, r_req.duration_secs};
    assign add_full = (r_req.op == OP_ADD) && !r_found && !r_free_found;

    always_comb begin
        we       = 1'b0;
        waddr    = r_pidx;
        wr_entry = '0;
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_rd_cnt[IW-1:0];
            end
            S_SCAN: begin
                // Purges erase behind the read pointer, so no entry is read
                // and written in the same cycle.
                we = r_pv && purge_sel;
            end
            S_FINISH: begin
                case (r_req.op)
                    OP_CHECK: begin
                        we    = r_found && (r_rem == 31'd0);
                        waddr = r_hit_idx;
                    end
                    OP_ADD: begin
                        wr_entry.valid    = 1'b1;
                        wr_entry.addr     = r_req.peer_ip;
                        wr_entry.udp_port = r_req.peer_port;
                        wr_entry.expiry   = new_exp;
                        we    = r_found || r_free_found;
                        waddr = r_found ? r_hit_idx : r_free_idx;
                    end
                    OP_REMOVE: begin
                        we    = r_found;
                        waddr = r_hit_idx;
                    end
                    default: begin
                        we = 1'b0;
                    end
                endcase
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    pbl_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (r_rd_cnt[IW-1:0]),
        .o_rdata (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_rd_cnt <= '0;
            r_pv     <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_rd_cnt <= r_rd_cnt + 1'b1;
                    if (r_rd_cnt == CW'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_req        <= i_req;
                        r_rd_cnt     <= '0;
                        r_pv         <= 1'b0;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_rem        <= '0;
                        r_count      <= '0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                    end
                    r_pv   <= rd_en;
                    r_pidx <= r_rd_cnt[IW-1:0];
                    if (r_pv) begin
                        if (is_lookup && hit && !r_found) begin
                            r_found   <= 1'b1;
                            r_hit_idx <= r_pidx;
                            r_rem     <= expired ? 31'd0 : diff[30:0];
                        end
                        if (!rd_entry.valid && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_pidx;
                        end
                        if (purge_sel && (r_count != PBL_COUNT_MAX)) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (!rd_en) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    r_done               <= 1'b1;
                    r_rsp.remaining_secs <= r_rem;
                    r_rsp.status         <= add_full;
                    r_rsp.purged_count   <= r_count;
                    r_state              <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/pbl_checker.sv =====
module pbl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input pbl_pkg::t_rsp o_rsp
);
    import pbl_pkg::*;

    // An accepted word keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted word");

    // A result only closes out a request that was in progress.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe without a request in progress");

    // Every request sweeps the table, so two strobes are never adjacent.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe repeated");

    // A dropped add reports nothing else.
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status |-> o_rsp.remaining_secs == 31'd0
                                   && o_rsp.purged_count == '0)
        else $error("table full result carries other fields");

    // A purge count and remaining seconds never come in the same word.
    a_purge_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_rsp.purged_count != '0) |-> o_rsp.remaining_secs == 31'd0
                                                 && !o_rsp.status)
        else $error("purge result carries lookup fields");

endmodule

bind peer_blocklist_with_expiry pbl_checker u_pbl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
